FILE: src/bisection_finish_time_search_unit_defines.svh
// Assertion macros for the checker file of the bisection search unit.
`ifndef BISECTION_FINISH_TIME_SEARCH_UNIT_DEFINES_SVH
`define BISECTION_FINISH_TIME_SEARCH_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BFTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BFTS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/bfts_pkg.sv
// Types and constants of the bisection finish time search unit.
package bfts_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int NS_BITS_DEF   = 56;

    localparam int MS_W   = 36;
    localparam int SUB_W  = 48;
    localparam int PROBE_W = 64;
    localparam int BOUND_W = 56;
    localparam int TICK_W = 56;

    localparam logic [TICK_W-1:0] NS_PER_MS = TICK_W'(1000000);

    typedef enum logic
    {
        ACT_START,
        ACT_ANSWER
    } action_t;

    typedef enum logic [1:0]
    {
        KIND_PROBE,
        KIND_DONE,
        KIND_REJECT,
        KIND_UNFINISHED
    } kind_t;

    typedef struct packed
    {
        action_t            action;
        logic [MS_W-1:0]    tick_time_ms;
        logic [MS_W-1:0]    tick_period_ms;
        logic [SUB_W-1:0]   substep_start_ns;
        logic [SUB_W-1:0]   substep_duration_ns;
        logic               probe_true;
    } cmd_t;

    typedef struct packed
    {
        kind_t              kind;
        logic [PROBE_W-1:0] probe_offset_ns;
        logic [BOUND_W-1:0] lower_bound_ns;
        logic [BOUND_W-1:0] upper_bound_ns;
        logic [BOUND_W-1:0] estimated_ns;
    } res_t;

endpackage

FILE: src/bisection_finish_time_search_unit.sv
// Top level of the bisection finish time search unit.
//
// Usage
//   cmd channel (cmd_valid/cmd_ready/cmd): one beat is either a start of a new
//   search (tick time, tick period, substep start and duration) or the
//   oracle's answer to the last probe request.
//   res channel (res_valid/res_ready/res): one beat per command that has a
//   result: a probe request, the final bounds, a rejected start, or a
//   report that the substep did not finish within its full duration. An
//   answer that arrives while no search runs produces no beat.
//   Path: an accepted command is held in the input register; its result
//   lands in the result register once that register is free or being
//   taken, and is offered from there.
//   Throughput: one command per cycle while res_ready is high. The
//   start path's constant multiply runs in the input register stage; range
//   check, bound update and the next midpoint take at most two adds and a
//   compare in the result stage. Stall: while res_ready is low the result
//   register holds; the input register still takes one more command, then
//   cmd_ready drops. cmd_ready depends combinationally on res_ready.
//   Reset: asynchronous, clears both valid flags and returns to idle.
module bisection_finish_time_search_unit #(
    parameter int FRAC_BITS = bfts_pkg::FRAC_BITS_DEF,
    parameter int NS_BITS   = bfts_pkg::NS_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  bfts_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output bfts_pkg::res_t res
);

    localparam int TICK_W = bfts_pkg::TICK_W;
    localparam int SUB_W  = bfts_pkg::SUB_W;
    // Wide enough for tick_ns << FRAC_BITS plus start, duration and rounding.
    localparam int WIDE_W = ((TICK_W + FRAC_BITS > 64) ? TICK_W + FRAC_BITS : 64) + 2;

    localparam logic [63:0] NS_MASK   = (64'd1 << NS_BITS) - 64'd1;
    localparam logic [63:0] Q_LIMIT   = {64{1'b1}} >> FRAC_BITS;
    localparam logic [63:0] MAX_NS    = (NS_MASK < Q_LIMIT) ? NS_MASK : Q_LIMIT;
    localparam logic [WIDE_W-1:0] MAX_NS_W  = WIDE_W'(MAX_NS);
    localparam logic [WIDE_W-1:0] MAX_Q_W   = MAX_NS_W << FRAC_BITS;
    localparam logic [SUB_W:0]    FRAC_MASK = (SUB_W+1)'((64'd1 << FRAC_BITS) - 64'd1);

    typedef enum logic [1:0]
    {
        PH_IDLE,
        PH_FIRST,
        PH_SEARCH
    } phase_t;

    // Input register stage.
    logic                 s1_valid_reg;
    bfts_pkg::action_t    s1_action_reg;
    logic                 s1_yes_reg;
    logic                 s1_order_bad_reg;
    logic [TICK_W-1:0]    s1_tick_ns_reg;
    logic [SUB_W-1:0]     s1_start_reg;
    logic [SUB_W-1:0]     s1_dur_reg;
    logic [SUB_W:0]       s1_dur_rnd_reg;

    // Search state and result register.
    phase_t               phase_reg,  phase_next;
    logic [NS_BITS-1:0]   floor_reg,  floor_next;
    logic [NS_BITS-1:0]   ceil_reg,   ceil_next;
    logic [NS_BITS-1:0]   cand_reg,   cand_next;
    logic [63:0]          origin_reg, origin_next;
    logic                 res_valid_reg, res_valid_next;
    bfts_pkg::res_t       res_reg,    res_next;

    logic                 advance;
    logic                 s2_fire;
    logic [bfts_pkg::MS_W-1:0] tick_diff;

    logic [WIDE_W-1:0]    lo_w;
    logic [WIDE_W-1:0]    base_w;
    logic [WIDE_W-1:0]    top_w;
    logic [WIDE_W-1:0]    ceil_w;
    logic                 reject;

    logic [NS_BITS-1:0]   fl_a;
    logic [NS_BITS-1:0]   ch_a;
    logic [NS_BITS:0]     fl_inc;
    logic [NS_BITS:0]     mid_sum;
    logic [NS_BITS-1:0]   mid;
    logic                 done;
    logic [WIDE_W-1:0]    mid_q;
    logic [63:0]          probe;

    // Move the result stage when the result register is free or being taken.
    assign advance   = !res_valid_reg || res_ready;
    assign s2_fire   = s1_valid_reg && advance;
    assign cmd_ready = !s1_valid_reg || advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign tick_diff = cmd.tick_time_ms - cmd.tick_period_ms;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            s1_valid_reg <= cmd_valid;
        end
    end

    // Hold the accepted beat; the constant multiply lives here.
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            s1_action_reg    <= cmd.action;
            s1_yes_reg       <= cmd.probe_true;
            s1_order_bad_reg <= cmd.tick_time_ms < cmd.tick_period_ms;
            s1_tick_ns_reg   <= TICK_W'(tick_diff) * bfts_pkg::NS_PER_MS;
            s1_start_reg     <= cmd.substep_start_ns;
            s1_dur_reg       <= cmd.substep_duration_ns;
            s1_dur_rnd_reg   <= (SUB_W+1)'(cmd.substep_duration_ns) + FRAC_MASK;
        end
    end

    // Start path: form the fixed-point bounds and check the range.
    always_comb
    begin
        lo_w   = WIDE_W'(s1_tick_ns_reg) << FRAC_BITS;
        base_w = lo_w + WIDE_W'(s1_start_reg);
        top_w  = base_w + WIDE_W'(s1_dur_reg);
        ceil_w = base_w + WIDE_W'(s1_dur_rnd_reg);
        reject = s1_order_bad_reg || (s1_dur_reg == '0)
              || (WIDE_W'(s1_tick_ns_reg) > MAX_NS_W) || (top_w > MAX_Q_W);
    end

    // Answer path: apply the answer, then pick the next midpoint or finish.
    always_comb
    begin
        fl_a = floor_reg;
        ch_a = ceil_reg;
        if (phase_reg == PH_SEARCH)
        begin
            if (s1_yes_reg)
            begin
                ch_a = cand_reg;
            end
            else
            begin
                fl_a = cand_reg;
            end
        end
        fl_inc  = {1'b0, fl_a} + (NS_BITS+1)'(1);
        mid_sum = {1'b0, fl_a} + {1'b0, ch_a};
        mid     = mid_sum[NS_BITS:1];
        done    = (ch_a == '0) || (fl_inc >= {1'b0, ch_a});
        mid_q   = WIDE_W'(mid) << FRAC_BITS;
        probe   = mid_q[63:0] - origin_reg;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        floor_next     = floor_reg;
        ceil_next      = ceil_reg;
        cand_next      = cand_reg;
        origin_next    = origin_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (advance)
        begin
            res_valid_next = 1'b0;
            res_next       = '0;
        end

        if (s2_fire)
        begin
            if (s1_action_reg == bfts_pkg::ACT_START)
            begin
                // A start always drops any running search.
                res_valid_next = 1'b1;
                if (reject)
                begin
                    phase_next    = PH_IDLE;
                    res_next.kind = bfts_pkg::KIND_REJECT;
                end
                else
                begin
                    phase_next               = PH_FIRST;
                    floor_next               = base_w[FRAC_BITS +: NS_BITS];
                    ceil_next                = ceil_w[FRAC_BITS +: NS_BITS];
                    origin_next              = base_w[63:0];
                    res_next.kind            = bfts_pkg::KIND_PROBE;
                    res_next.probe_offset_ns = bfts_pkg::PROBE_W'(s1_dur_reg);
                end
            end
            else
            begin
                case (phase_reg)
                    PH_FIRST, PH_SEARCH:
                    begin
                        res_valid_next = 1'b1;
                        if (phase_reg == PH_FIRST && !s1_yes_reg)
                        begin
                            phase_next    = PH_IDLE;
                            res_next.kind = bfts_pkg::KIND_UNFINISHED;
                        end
                        else if (done)
                        begin
                            phase_next              = PH_IDLE;
                            floor_next              = fl_a;
                            ceil_next               = ch_a;
                            res_next.kind           = bfts_pkg::KIND_DONE;
                            res_next.lower_bound_ns = bfts_pkg::BOUND_W'(fl_a);
                            res_next.upper_bound_ns = bfts_pkg::BOUND_W'(ch_a);
                            res_next.estimated_ns   = bfts_pkg::BOUND_W'(ch_a);
                        end
                        else
                        begin
                            phase_next               = PH_SEARCH;
                            floor_next               = fl_a;
                            ceil_next                = ch_a;
                            cand_next                = mid;
                            res_next.kind            = bfts_pkg::KIND_PROBE;
                            res_next.probe_offset_ns = probe;
                        end
                    end
                    default:
                    begin
                        // Drop an answer that arrives with no search running.
                        res_valid_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            floor_reg     <= '0;
            ceil_reg      <= '0;
            cand_reg      <= '0;
            origin_reg    <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            floor_reg     <= floor_next;
            ceil_reg      <= ceil_next;
            cand_reg      <= cand_next;
            origin_reg    <= origin_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

endmodule

FILE: src/bfts_checker.sv
// Port-level checker for the bisection search unit and its bind statement.
`include "bisection_finish_time_search_unit_defines.svh"

module bfts_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_ready,
    input logic           res_valid,
    input logic           res_ready,
    input bfts_pkg::res_t res
);

    `BFTS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !res_valid, "result beat offered in reset")

    `BFTS_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res), "stalled result beat changed")

    `BFTS_ASSERT(a_ready_when_empty, !res_valid |-> cmd_ready, "command side stalled with no result beat waiting")

    `BFTS_ASSERT(a_probe_only, res_valid && res.kind != bfts_pkg::KIND_PROBE |-> res.probe_offset_ns == '0, "probe offset set on a non-probe beat")

    `BFTS_ASSERT(a_done_bounds, res_valid && res.kind == bfts_pkg::KIND_DONE |-> res.upper_bound_ns == res.lower_bound_ns + 56'd1 && res.estimated_ns == res.upper_bound_ns, "final bounds not one ns apart")

endmodule

bind bisection_finish_time_search_unit bfts_checker u_bfts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

FILE: bench/tb_bisection_finish_time_search_unit.sv
// Self-checking testbench for the bisection finish time search unit.
`timescale 1ns / 100ps

module tb_bisection_finish_time_search_unit;

    localparam int          FRAC        = bfts_pkg::FRAC_BITS_DEF;
    localparam int          MS_W        = bfts_pkg::MS_W;
    localparam int          SUB_W       = bfts_pkg::SUB_W;
    localparam int          BOUND_W     = bfts_pkg::BOUND_W;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_ITEMS = 300;

    // Search progress as tracked on the bench side
    typedef enum logic [1:0]
    {
        SRCH_IDLE,
        SRCH_FIRST,
        SRCH_BISECT
    } search_phase_t;

    // How a table row is checked: by the predictor, against a typed-in beat,
    // or as a command that must not produce any beat
    typedef enum logic [1:0]
    {
        CHK_MODEL,
        CHK_FIXED,
        CHK_SILENT
    } chk_mode_t;

    typedef struct
    {
        bfts_pkg::cmd_t c;
        chk_mode_t      mode;
        bfts_pkg::res_t want;
    } stim_row_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b1;
    logic           cmd_valid = 1'b0;
    logic           cmd_ready;
    bfts_pkg::cmd_t cmd       = '0;
    logic           res_valid;
    logic           res_ready = 1'b0;
    bfts_pkg::res_t res;

    // Predictor state, all bounds in ns with FRAC fractional bits
    search_phase_t srch_phase = SRCH_IDLE;
    logic [63:0]   low_q      = '0;
    logic [63:0]   high_q     = '0;
    logic [63:0]   origin_q   = '0;
    logic [63:0]   mid_ns     = '0;

    bfts_pkg::res_t awaited_res[$];
    int unsigned    err_count    = 0;
    int unsigned    issued_items = 0;
    int unsigned    cycle_cnt    = 0;
    int unsigned    gap_pct      = 0;
    int unsigned    stall_pct    = 0;

    bisection_finish_time_search_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #4 clk = ~clk;

    // Bound the run: a hung handshake ends here
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bfts_pkg::res_t mk_res(input bfts_pkg::kind_t k,
                                              input logic [63:0] probe,
                                              input logic [BOUND_W-1:0] lo,
                                              input logic [BOUND_W-1:0] hi);
        bfts_pkg::res_t r;
        r                 = '0;
        r.kind            = k;
        r.probe_offset_ns = probe;
        r.lower_bound_ns  = lo;
        r.upper_bound_ns  = hi;
        r.estimated_ns    = hi;
        return r;
    endfunction

    function automatic bfts_pkg::cmd_t mk_start(input logic [MS_W-1:0] tt,
                                                input logic [MS_W-1:0] tp,
                                                input logic [SUB_W-1:0] st,
                                                input logic [SUB_W-1:0] du);
        bfts_pkg::cmd_t c;
        c                     = '0;
        c.action              = bfts_pkg::ACT_START;
        c.tick_time_ms        = tt;
        c.tick_period_ms      = tp;
        c.substep_start_ns    = st;
        c.substep_duration_ns = du;
        c.probe_true          = 1'($urandom_range(1));
        return c;
    endfunction

    // Answer beats carry random junk in the start fields; the unit must ignore it
    function automatic bfts_pkg::cmd_t mk_answer(input logic yes);
        bfts_pkg::cmd_t c;
        c            = mk_start(MS_W'(rand64()), MS_W'(rand64()), SUB_W'(rand64()),
                                SUB_W'(rand64()));
        c.action     = bfts_pkg::ACT_ANSWER;
        c.probe_true = yes;
        return c;
    endfunction

    // Issue the next midpoint probe, or close the search when no interior
    // whole nanosecond is left between the bounds
    function automatic bfts_pkg::res_t next_probe_or_done();
        logic [63:0]    first_ns;
        logic [63:0]    top_ns;
        bfts_pkg::res_t r;
        r        = '0;
        first_ns = (low_q >> FRAC) + 64'd1;
        top_ns   = (high_q >> FRAC) + ((high_q[FRAC-1:0] != '0) ? 64'd1 : 64'd0);
        if (top_ns == 64'd0 || first_ns >= top_ns)
        begin
            srch_phase = SRCH_IDLE;
            r = mk_res(bfts_pkg::KIND_DONE, 64'd0, BOUND_W'(low_q >> FRAC),
                       BOUND_W'(top_ns));
        end
        else
        begin
            mid_ns     = first_ns + ((top_ns - 64'd1) - first_ns) / 64'd2;
            srch_phase = SRCH_BISECT;
            r = mk_res(bfts_pkg::KIND_PROBE, (mid_ns << FRAC) - origin_q, '0, '0);
        end
        return r;
    endfunction

    // Advance the predicted search by one command; return 1 if a beat follows
    function automatic bit predict_search_step(input bfts_pkg::cmd_t c,
                                               output bfts_pkg::res_t r);
        logic [63:0] max_q;
        logic [63:0] tick_ns;
        logic [63:0] lo_q;
        logic [63:0] st_q;
        logic [63:0] du_q;
        logic [63:0] max_ns;
        r      = '0;
        max_ns = (64'd1 << bfts_pkg::NS_BITS_DEF) - 64'd1;
        if ((64'hFFFF_FFFF_FFFF_FFFF >> FRAC) < max_ns)
            max_ns = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC;
        max_q = max_ns << FRAC;
        if (c.action == bfts_pkg::ACT_START)
        begin
            st_q       = 64'(c.substep_start_ns);
            du_q       = 64'(c.substep_duration_ns);
            srch_phase = SRCH_IDLE;
            if (c.tick_time_ms < c.tick_period_ms || du_q == 64'd0)
            begin
                r.kind = bfts_pkg::KIND_REJECT;
                return 1'b1;
            end
            tick_ns = 64'(c.tick_time_ms) - 64'(c.tick_period_ms);
            tick_ns = tick_ns * 64'd1000000;
            if (tick_ns > max_ns)
            begin
                r.kind = bfts_pkg::KIND_REJECT;
                return 1'b1;
            end
            lo_q = tick_ns << FRAC;
            if (st_q > max_q - lo_q || du_q > max_q - lo_q - st_q)
            begin
                r.kind = bfts_pkg::KIND_REJECT;
                return 1'b1;
            end
            low_q      = lo_q + st_q;
            high_q     = low_q + du_q;
            origin_q   = low_q;
            srch_phase = SRCH_FIRST;
            r = mk_res(bfts_pkg::KIND_PROBE, du_q, '0, '0);
            return 1'b1;
        end
        if (srch_phase == SRCH_FIRST)
        begin
            if (!c.probe_true)
            begin
                srch_phase = SRCH_IDLE;
                r.kind     = bfts_pkg::KIND_UNFINISHED;
                return 1'b1;
            end
            r = next_probe_or_done();
            return 1'b1;
        end
        if (srch_phase == SRCH_BISECT)
        begin
            if (c.probe_true)
                high_q = mid_ns << FRAC;
            else
                low_q = mid_ns << FRAC;
            r = next_probe_or_done();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
        err_count++;
    endtask

    // Compare one result beat with the oldest awaited one, field by field
    task automatic check_beat(input bfts_pkg::res_t got);
        bfts_pkg::res_t want;
        if (awaited_res.size() == 0)
        begin
            report_mismatch("beat with nothing awaited, kind", 64'(got.kind), 64'd0);
            return;
        end
        want = awaited_res.pop_front();
        if (got.kind != want.kind)
            report_mismatch("kind", 64'(got.kind), 64'(want.kind));
        if (got.probe_offset_ns != want.probe_offset_ns)
            report_mismatch("probe_offset_ns", got.probe_offset_ns, want.probe_offset_ns);
        if (got.lower_bound_ns != want.lower_bound_ns)
            report_mismatch("lower_bound_ns", 64'(got.lower_bound_ns),
                            64'(want.lower_bound_ns));
        if (got.upper_bound_ns != want.upper_bound_ns)
            report_mismatch("upper_bound_ns", 64'(got.upper_bound_ns),
                            64'(want.upper_bound_ns));
        if (got.estimated_ns != want.estimated_ns)
            report_mismatch("estimated_ns", 64'(got.estimated_ns), 64'(want.estimated_ns));
    endtask

    // Result side: check every accepted beat, then pick the next ready level.
    // Sampling at the edge sees the values from before this edge's updates.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
                check_beat(res);
            res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Predict one command, queue what it should produce, then hold the beat
    // on the bus until the unit takes it. Valid is dropped only for a real gap,
    // so back-to-back beats never see a low/high pair in one time step.
    task automatic send_beat(input bfts_pkg::cmd_t c, input chk_mode_t mode,
                             input bfts_pkg::res_t want,
                             output bfts_pkg::res_t pred, output bit had);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct)
            gap++;
        had = predict_search_step(c, pred);
        if (had)
            issued_items++;
        case (mode)
            CHK_MODEL:
                if (had)
                    awaited_res.push_back(pred);
            CHK_FIXED:
                awaited_res.push_back(want);
            default:
                ;
        endcase
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    // Well-formed start: mostly a tick span of a few ms and short durations,
    // now and then a wide tick span or a full 48-bit duration
    function automatic bfts_pkg::cmd_t rand_search_start();
        logic [MS_W-1:0]  tt;
        logic [MS_W-1:0]  tp;
        logic [MS_W-1:0]  swap;
        logic [SUB_W-1:0] du;
        logic [MS_W-1:0]  span;
        tt = MS_W'(rand64());
        if ($urandom_range(7) != 0)
        begin
            span = MS_W'($urandom_range(3));
            if (tt < span)
                tt = span;
            tp = tt - span;
        end
        else
        begin
            tp = MS_W'(rand64());
            if (tp > tt)
            begin
                swap = tt;
                tt   = tp;
                tp   = swap;
            end
        end
        if ($urandom_range(15) == 0)
            du = SUB_W'(rand64());
        else
            du = SUB_W'(rand64()) & ((SUB_W'(1) << $urandom_range(1, 20)) - SUB_W'(1));
        if (du == '0)
            du = SUB_W'(1);
        return mk_start(tt, tp, SUB_W'(rand64()), du);
    endfunction

    // One search with an oracle that mostly tells the truth about a hidden
    // finish offset; a few answers lie and some searches are dropped midway
    task automatic run_search();
        bfts_pkg::cmd_t c;
        bfts_pkg::res_t pred;
        bit             had;
        logic [63:0]    finish_q;
        logic           yes;
        c = rand_search_start();
        if ($urandom_range(9) == 0)
            finish_q = 64'(c.substep_duration_ns) + 64'd1;
        else
            finish_q = rand64() % (64'(c.substep_duration_ns) + 64'd1);
        send_beat(c, CHK_MODEL, '0, pred, had);
        while (srch_phase != SRCH_IDLE && $urandom_range(39) != 0)
        begin
            yes = (pred.probe_offset_ns >= finish_q);
            if ($urandom_range(19) == 0)
                yes = ~yes;
            send_beat(mk_answer(yes), CHK_MODEL, '0, pred, had);
        end
    endtask

    // Noise: fully random commands, half of the starts rejected, answers
    // landing on idle or on a dropped search
    task automatic send_noise();
        bfts_pkg::cmd_t c;
        bfts_pkg::res_t pred;
        bit             had;
        c = mk_start(MS_W'(rand64()), MS_W'(rand64()), SUB_W'(rand64()), SUB_W'(rand64()));
        if ($urandom_range(1) == 1)
            c = mk_answer(1'($urandom_range(1)));
        send_beat(c, CHK_MODEL, '0, pred, had);
    endtask

    // Hold the command side idle until every awaited beat has come back
    task automatic drain_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (awaited_res.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        stim_row_t      dir_tbl[$];
        bfts_pkg::res_t pred;
        bit             had;
        int unsigned    phase_end;

        // Assert reset at time zero as a real falling edge
        rst_n <= 1'b0;

        // Directed rows: idle answers, the order and zero-duration rejects, field
        // extremes, the unfinished report, a search closed by its first yes, and
        // restarts dropped in both the first-probe and the bisecting state
        dir_tbl.push_back('{mk_answer(1'b1), CHK_SILENT, '0});
        dir_tbl.push_back('{mk_answer(1'b0), CHK_SILENT, '0});
        dir_tbl.push_back('{mk_start(36'd0, 36'd1, 48'd0, 48'd1), CHK_FIXED,
                            mk_res(bfts_pkg::KIND_REJECT, 64'd0, '0, '0)});
        dir_tbl.push_back('{mk_start(36'd5, 36'd5, 48'h100, 48'd0), CHK_FIXED,
                            mk_res(bfts_pkg::KIND_REJECT, 64'd0, '0, '0)});
        dir_tbl.push_back('{mk_start('1, '1, '1, 48'd0), CHK_FIXED,
                            mk_res(bfts_pkg::KIND_REJECT, 64'd0, '0, '0)});
        dir_tbl.push_back('{mk_start('1, 36'd0, '1, '1), CHK_FIXED,
                            mk_res(bfts_pkg::KIND_PROBE, 64'h0000_FFFF_FFFF_FFFF, '0, '0)});
        dir_tbl.push_back('{mk_answer(1'b0), CHK_FIXED,
                            mk_res(bfts_pkg::KIND_UNFINISHED, 64'd0, '0, '0)});
        dir_tbl.push_back('{mk_answer(1'b1), CHK_SILENT, '0});
        dir_tbl.push_back('{mk_start(36'd0, 36'd0, 48'd0, 48'd1), CHK_FIXED,
                            mk_res(bfts_pkg::KIND_PROBE, 64'd1, '0, '0)});
        dir_tbl.push_back('{mk_answer(1'b1), CHK_FIXED,
                            mk_res(bfts_pkg::KIND_DONE, 64'd0, 56'd0, 56'd1)});
        dir_tbl.push_back('{mk_start(36'd3, 36'd2, 48'h40, 48'h300), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_answer(1'b1), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_answer(1'b0), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_answer(1'b1), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_answer(1'b0), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_start(36'd7, 36'd3, 48'h1234, 48'h10000), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_start(36'd9, 36'd9, 48'h0, 48'h2000), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_answer(1'b1), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_answer(1'b0), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_start(36'd2, 36'd1, 48'h80, 48'h800), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_answer(1'b1), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_answer(1'b1), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_answer(1'b1), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_answer(1'b1), CHK_MODEL, '0});
        dir_tbl.push_back('{mk_answer(1'b1), CHK_MODEL, '0});

        // Hold reset, then release it once and never again
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table with no idling on either side
        foreach (dir_tbl[i])
            send_beat(dir_tbl[i].c, dir_tbl[i].mode, dir_tbl[i].want, pred, had);
        drain_results();

        // Random phases: free flow, sender gaps, receiver stalls, then both
        // lightly; drain between phases so the sender pauses with nothing open
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 49; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 49; end
                default: begin gap_pct = 8;  stall_pct = 8;  end
            endcase
            phase_end = issued_items + PHASE_ITEMS;
            while (issued_items < phase_end)
            begin
                if ($urandom_range(99) < 80)
                    run_search();
                else
                    send_noise();
            end
            drain_results();
        end

        // Let the pipe settle so a stray beat still gets caught
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/bfts_pkg.sv
src/bisection_finish_time_search_unit.sv
src/bfts_checker.sv
bench/tb_bisection_finish_time_search_unit.sv
